// ===== hdl/sphere_pair_relation_macros.svh =====
// Assertion macros shared by the checker.
`ifndef SPHERE_PAIR_RELATION_MACROS_SVH
`define SPHERE_PAIR_RELATION_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spr_pkg.sv =====
`default_nettype none

package spr_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned SHIFT_BITS      = 6;
    localparam int unsigned SHIFT_RESET     = 20;
    localparam int unsigned RADIUS_BITS     = 31;
    localparam int unsigned DIST_BITS       = 33;
    localparam int unsigned ROOT_BITS       = 50;
    localparam int unsigned SUM_BITS        = 100;
    localparam int unsigned CMP_BITS        = 64;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic [RADIUS_BITS-1:0] first_radius;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic [RADIUS_BITS-1:0] second_radius;
    } t_in_req;

    typedef struct packed {
        logic [DIST_BITS-1:0] centre_distance;
        logic congruent;
        logic concentric;
        logic identical;
        logic touch_outside;
        logic touch_inside;
        logic overlapping;
        logic first_inside_second;
        logic second_inside_first;
        logic intersecting;
    } t_out_req;

    // Data handed from one square-root cell to the next.
    typedef struct packed {
        logic                   valid;
        logic [SUM_BITS-1:0]    rem;
        logic [ROOT_BITS-1:0]   root;
        logic [RADIUS_BITS-1:0] r1;
        logic [RADIUS_BITS-1:0] r2;
        logic                   congruent;
        logic                   concentric;
        logic [SHIFT_BITS-1:0]  shift;
    } t_cell_req;

    function automatic logic [CMP_BITS-1:0] f_mag(input logic signed [CMP_BITS-1:0] v);
        f_mag = v[CMP_BITS-1] ? CMP_BITS'(-v) : v;
    endfunction

    function automatic logic f_near(input logic signed [CMP_BITS-1:0] a,
                                    input logic signed [CMP_BITS-1:0] b,
                                    input logic [SHIFT_BITS-1:0] s);
        logic [CMP_BITS-1:0] t;
        t = f_mag(a) + f_mag(b);
        if (a == b) begin
            f_near = 1'b1;
        end else if (t == '0) begin
            f_near = 1'b0;
        end else begin
            f_near = f_mag(a - b) <= ((t - CMP_BITS'(1)) >> s);
        end
    endfunction

    function automatic logic f_greater(input logic signed [CMP_BITS-1:0] a,
                                       input logic signed [CMP_BITS-1:0] b,
                                       input logic [SHIFT_BITS-1:0] s);
        logic [CMP_BITS-1:0] t;
        t = f_mag(a) + f_mag(b);
        if (a <= b) begin
            f_greater = 1'b0;
        end else begin
            f_greater = CMP_BITS'(a - b) > (t >> s);
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sphere_pair_relation.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_req (t_in_req)
// out       output     o_out_valid / i_out_ready  o_out_req (t_out_req)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (tolerance shift)
//
// One request enters per cycle while the output is not stalled; its result passes through the front register,
// the chain of square-root cells (one root bit per cell) and the back register before it is valid.
// A stall on the output freezes the whole chain, since every stage moves together.
// Reset is synchronous and active low; it clears the valid bits and sets the shift to 20.
`default_nettype none

module sphere_pair_relation #(
    parameter int unsigned COORD_WIDTH = spr_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire spr_pkg::t_in_req              i_in_req,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output spr_pkg::t_out_req                  o_out_req,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [spr_pkg::SHIFT_BITS-1:0] i_cfg_data
);
    import spr_pkg::*;

    logic en;
    logic [SHIFT_BITS-1:0] r_shift;
    t_cell_req chain [ROOT_BITS+1];

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_BITS'(SHIFT_RESET);
        end else if (i_cfg_valid) begin
            r_shift <= i_cfg_data;
        end
    end

    spr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid),
        .i_req(i_in_req), .i_shift(r_shift), .o_cell(chain[0])
    );

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
        spr_cell #(.BIT(ROOT_BITS - 1 - g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_cell(chain[g]), .o_cell(chain[g+1])
        );
    end

    spr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_cell(chain[ROOT_BITS]),
        .o_valid(o_out_valid), .o_req(o_out_req)
    );

endmodule

`default_nettype wire

// ===== hdl/spr_front.sv =====
`default_nettype none

module spr_front #(
    parameter int unsigned COORD_WIDTH = spr_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire spr_pkg::t_in_req              i_req,
    input  wire logic [spr_pkg::SHIFT_BITS-1:0] i_shift,
    output spr_pkg::t_cell_req                 o_cell
);
    import spr_pkg::*;

    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned SQ = 2 * DW;

    logic signed [COORD_WIDTH-1:0] c1 [3];
    logic signed [COORD_WIDTH-1:0] c2 [3];
    logic [DW-1:0] dmag [3];
    logic [SQ-1:0] r_sq [3], n_sq [3];
    logic [2:0] nearc;
    logic r_valid, n_valid, r_cong, n_cong, r_conc, n_conc;
    logic [RADIUS_BITS-1:0] r_r1, r_r2;
    logic [SHIFT_BITS-1:0] r_shift;
    logic signed [DW-1:0] diff;

    always_comb begin
        c1[0] = COORD_WIDTH'($unsigned(i_req.first_x));
        c1[1] = COORD_WIDTH'($unsigned(i_req.first_y));
        c1[2] = COORD_WIDTH'($unsigned(i_req.first_z));
        c2[0] = COORD_WIDTH'($unsigned(i_req.second_x));
        c2[1] = COORD_WIDTH'($unsigned(i_req.second_y));
        c2[2] = COORD_WIDTH'($unsigned(i_req.second_z));
        diff = '0;
        for (int k = 0; k < 3; k++) begin
            diff = DW'(c1[k]) - DW'(c2[k]);
            dmag[k] = diff[DW-1] ? DW'(-diff) : DW'(diff);
            n_sq[k] = SQ'(dmag[k]) * SQ'(dmag[k]);
            nearc[k] = f_near(CMP_BITS'(c1[k]), CMP_BITS'(c2[k]), i_shift);
        end
        n_valid = i_valid;
        n_cong = f_near(CMP_BITS'(i_req.first_radius), CMP_BITS'(i_req.second_radius),
                        i_shift);
        n_conc = &nearc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= n_sq[k];
            end
            r_cong  <= n_cong;
            r_conc  <= n_conc;
            r_r1    <= i_req.first_radius;
            r_r2    <= i_req.second_radius;
            r_shift <= i_shift;
        end
    end

    always_comb begin
        o_cell            = '0;
        o_cell.valid      = r_valid;
        o_cell.rem        = SUM_BITS'(r_sq[0]) + SUM_BITS'(r_sq[1]) + SUM_BITS'(r_sq[2]);
        o_cell.root       = '0;
        o_cell.r1         = r_r1;
        o_cell.r2         = r_r2;
        o_cell.congruent  = r_cong;
        o_cell.concentric = r_conc;
        o_cell.shift      = r_shift;
    end

endmodule

`default_nettype wire

// ===== hdl/spr_cell.sv =====
`default_nettype none

module spr_cell #(
    parameter int unsigned BIT = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire spr_pkg::t_cell_req i_cell,
    output spr_pkg::t_cell_req      o_cell
);
    import spr_pkg::*;

    localparam int unsigned TW = SUM_BITS + 2;

    logic [TW-1:0] trial;
    logic [TW-1:0] rem_w;
    logic take;
    t_cell_req r_cell, n_cell;

    // Restoring digit step: adding bit BIT to the root costs root * 2^(BIT+1) + 2^(2*BIT).
    always_comb begin
        trial = (TW'(i_cell.root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        rem_w = TW'(i_cell.rem);
        take  = rem_w >= trial;
        n_cell = i_cell;
        if (take) begin
            n_cell.rem  = SUM_BITS'(rem_w - trial);
            n_cell.root = i_cell.root | (ROOT_BITS'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.rem        <= n_cell.rem;
            r_cell.root       <= n_cell.root;
            r_cell.r1         <= n_cell.r1;
            r_cell.r2         <= n_cell.r2;
            r_cell.congruent  <= n_cell.congruent;
            r_cell.concentric <= n_cell.concentric;
            r_cell.shift      <= n_cell.shift;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ===== hdl/spr_back.sv =====
`default_nettype none

module spr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire spr_pkg::t_cell_req i_cell,
    output logic                    o_valid,
    output spr_pkg::t_out_req       o_req
);
    import spr_pkg::*;

    logic [ROOT_BITS-1:0] q;
    logic signed [CMP_BITS-1:0] d, r1, r2, dr1, dr2, rs;
    logic n_in1, n_in2, n_tin, n_ovl, n_tout;
    logic r_valid;
    t_out_req r_req, n_req;

    // The remainder is S - q*q, so rounding up is remainder above q.
    always_comb begin
        q  = i_cell.root + ROOT_BITS'(i_cell.rem > SUM_BITS'(i_cell.root));
        d  = CMP_BITS'(q);
        r1 = CMP_BITS'(i_cell.r1);
        r2 = CMP_BITS'(i_cell.r2);
        dr1 = d + r1;
        dr2 = d + r2;
        rs  = r1 + r2;
        n_tout = f_near(d, rs, i_cell.shift);
        n_tin  = !i_cell.congruent && (f_near(r1, dr2, i_cell.shift) ||
                                       f_near(r2, dr1, i_cell.shift));
        n_ovl  = f_greater(rs, d, i_cell.shift);
        n_in1  = f_greater(r2, dr1, i_cell.shift) || f_near(r2, dr1, i_cell.shift);
        n_in2  = f_greater(r1, dr2, i_cell.shift) || f_near(r1, dr2, i_cell.shift);
        n_req.centre_distance = (q > ROOT_BITS'({DIST_BITS{1'b1}})) ?
                                {DIST_BITS{1'b1}} : DIST_BITS'(q);
        n_req.congruent           = i_cell.congruent;
        n_req.concentric          = i_cell.concentric;
        n_req.identical           = i_cell.congruent && i_cell.concentric;
        n_req.touch_outside       = n_tout;
        n_req.touch_inside        = n_tin;
        n_req.overlapping         = n_ovl;
        n_req.first_inside_second = n_in1;
        n_req.second_inside_first = n_in2;
        n_req.intersecting        = n_ovl && !n_in1 && !n_in2 && !n_tin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_cell.valid;
        end
        if (i_en) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

`default_nettype wire

// ===== hdl/spr_checker.sv =====
`default_nettype none
`include "sphere_pair_relation_macros.svh"

module spr_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire spr_pkg::t_out_req o_out_req
);
    `SPR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_req), "result changed while stalled")
    `SPR_ASSERT_IMPL(a_ident, i_clk, i_rst_n, o_out_valid, o_out_req.identical == (o_out_req.congruent && o_out_req.concentric), "identical flag wrong")
    `SPR_ASSERT_IMPL(a_cross, i_clk, i_rst_n, o_out_valid && o_out_req.intersecting, o_out_req.overlapping && !o_out_req.touch_inside, "intersecting without overlap")
    `SPR_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with empty output")
endmodule

bind sphere_pair_relation spr_checker u_spr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_req(o_out_req)
);

`default_nettype wire
